// ----- design/spa_pkg.sv -----
// Package for the sparse polynomial adder: sizes, command codes and shared types.
// Used by the term RAM, the merge core and the top level. No dependencies.

package spa_pkg;

  // Capacity of each term store (1 to 32).
  localparam int MaxTerms = 32;
  localparam int AddrW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int CntW     = $clog2(MaxTerms + 1);

  localparam int ExpW  = 16;
  localparam int CoefW = 32;

  // Command codes carried by kind.
  localparam logic [1:0] KindLoadFirst  = 2'd0;
  localparam logic [1:0] KindLoadSecond = 2'd1;
  localparam logic [1:0] KindMerge      = 2'd2;

  typedef struct packed {
    logic [ExpW-1:0]         exp;
    logic signed [CoefW-1:0] coef;
  } spa_term_t;

  // Access bundle from the merge core to one term RAM.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    spa_term_t        wdata;
    logic [AddrW-1:0] raddr;
  } spa_ram_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } spa_state_e;

endpackage

// ----- design/spa_term_ram.sv -----
// Term store: one write port and one read port, read data registered.
// Depends on spa_pkg for depth and the term and request types.

module spa_term_ram
  import spa_pkg::*;
(
  input  logic         clk_i,
  input  spa_ram_req_t req_i,
  output spa_term_t    rdata_o
);

  spa_term_t mem [MaxTerms];
  spa_term_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/spa_merge_core.sv -----
// Merge core: load counters, drop flag, two-pointer merge over the term RAMs,
// one-word hold stage for the last-term mark, and the output registers.
// Depends on spa_pkg.

module spa_merge_core
  import spa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind_i,
  input  logic [ExpW-1:0]         exponent_i,
  input  logic signed [CoefW-1:0] coefficient_i,
  output spa_ram_req_t            req_first_o,
  output spa_ram_req_t            req_second_o,
  input  spa_term_t               rdata_first_i,
  input  spa_term_t               rdata_second_i,
  output logic                    strobe_o,
  output logic [ExpW-1:0]         term_exponent_o,
  output logic signed [CoefW-1:0] term_coefficient_o,
  output logic                    last_term_o,
  output logic                    empty_sum_o,
  output logic                    overflow_seen_o
);

  spa_state_e state_q, state_d;

  logic [CntW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CntW-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic            dropped_q, dropped_d;

  logic      pend_vld_q, pend_vld_d;
  spa_term_t pend_q, pend_d;

  logic                    out_stb_q, out_stb_d;
  logic [ExpW-1:0]         out_exp_q, out_exp_d;
  logic signed [CoefW-1:0] out_coef_q, out_coef_d;
  logic                    out_last_q, out_last_d, out_empty_q, out_empty_d;
  logic                    out_ovf_q, out_ovf_d;

  logic accept, load_a, load_b, go;
  logic a_vld, b_vld, a_lt, exp_eq, take_a, take_b;
  logic step_live, run_end, nz;
  logic signed [CoefW:0]   sum_w;
  logic signed [CoefW-1:0] sum_sat, new_coef;
  logic [ExpW-1:0]         new_exp;

  assign accept = start && !busy;
  assign load_a = accept && (kind_i == KindLoadFirst);
  assign load_b = accept && (kind_i == KindLoadSecond);
  assign go     = accept && (kind_i == KindMerge);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (go) state_d = ST_MERGE;
      ST_MERGE: if (!a_vld && !b_vld) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy      = 1'b0;
    step_live = 1'b0;
    run_end   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_MERGE: begin
        busy      = 1'b1;
        step_live = a_vld || b_vld;
        run_end   = !a_vld && !b_vld;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Merge decision on the terms read at the current pointers.
  assign a_vld  = ptr_a_q < cnt_a_q;
  assign b_vld  = ptr_b_q < cnt_b_q;
  assign a_lt   = rdata_first_i.exp < rdata_second_i.exp;
  assign exp_eq = rdata_first_i.exp == rdata_second_i.exp;
  assign take_a = a_vld && (!b_vld || a_lt || exp_eq);
  assign take_b = b_vld && (!a_vld || !a_lt);

  assign sum_w = {rdata_first_i.coef[CoefW-1], rdata_first_i.coef}
               + {rdata_second_i.coef[CoefW-1], rdata_second_i.coef};

  always_comb begin
    if (sum_w[CoefW] != sum_w[CoefW-1]) begin
      sum_sat = sum_w[CoefW] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      sum_sat = sum_w[CoefW-1:0];
    end
  end

  always_comb begin
    if (take_a && take_b) begin
      new_coef = sum_sat;
    end else if (take_a) begin
      new_coef = rdata_first_i.coef;
    end else begin
      new_coef = rdata_second_i.coef;
    end
    new_exp = take_a ? rdata_first_i.exp : rdata_second_i.exp;
  end

  assign nz = new_coef != '0;

  // Counters, pointers, hold stage and output words.
  always_comb begin
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    dropped_d  = dropped_q;
    ptr_a_d    = '0;
    ptr_b_d    = '0;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_stb_d  = 1'b0;
    out_exp_d  = pend_q.exp;
    out_coef_d = pend_q.coef;
    out_last_d = 1'b0;
    out_empty_d = 1'b0;
    out_ovf_d  = dropped_q;

    if (load_a) begin
      if (cnt_a_q < CntW'(MaxTerms)) begin
        cnt_a_d = cnt_a_q + CntW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (load_b) begin
      if (cnt_b_q < CntW'(MaxTerms)) begin
        cnt_b_d = cnt_b_q + CntW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end

    if (step_live) begin
      ptr_a_d = ptr_a_q + CntW'(take_a);
      ptr_b_d = ptr_b_q + CntW'(take_b);
      if (nz) begin
        // A new nonzero term releases the held one, which is then known not last.
        out_stb_d  = pend_vld_q;
        pend_vld_d = 1'b1;
        pend_d.exp  = new_exp;
        pend_d.coef = new_coef;
      end
    end

    if (run_end) begin
      out_stb_d   = 1'b1;
      out_last_d  = 1'b1;
      out_empty_d = !pend_vld_q;
      if (!pend_vld_q) begin
        out_exp_d  = '0;
        out_coef_d = '0;
      end
      pend_vld_d = 1'b0;
      cnt_a_d    = '0;
      cnt_b_d    = '0;
      dropped_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      ptr_a_q    <= '0;
      ptr_b_q    <= '0;
      dropped_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      out_stb_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      ptr_a_q    <= ptr_a_d;
      ptr_b_q    <= ptr_b_d;
      dropped_q  <= dropped_d;
      pend_vld_q <= pend_vld_d;
      out_stb_q  <= out_stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    out_exp_q   <= out_exp_d;
    out_coef_q  <= out_coef_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
  end

  // Writes happen only while idle and read data is used only while merging,
  // so a write never meets a read whose data is used on the same entry.
  always_comb begin
    req_first_o.we     = load_a && (cnt_a_q < CntW'(MaxTerms));
    req_first_o.waddr  = cnt_a_q[AddrW-1:0];
    req_first_o.wdata.exp  = exponent_i;
    req_first_o.wdata.coef = coefficient_i;
    req_first_o.raddr  = ptr_a_d[AddrW-1:0];
    req_second_o.we    = load_b && (cnt_b_q < CntW'(MaxTerms));
    req_second_o.waddr = cnt_b_q[AddrW-1:0];
    req_second_o.wdata.exp  = exponent_i;
    req_second_o.wdata.coef = coefficient_i;
    req_second_o.raddr = ptr_b_d[AddrW-1:0];
  end

  assign strobe_o           = out_stb_q;
  assign term_exponent_o    = out_exp_q;
  assign term_coefficient_o = out_coef_q;
  assign last_term_o        = out_last_q;
  assign empty_sum_o        = out_empty_q;
  assign overflow_seen_o    = out_ovf_q;

endmodule

// ----- design/sparse_polynomial_add_unit.sv -----
// Sparse polynomial adder. A load word is taken and busy stays low.
// A merge word holds busy high through k merge steps and the run end, k
// being between max(na,nb) and na+nb; the steps are the read-compare-advance
// loop around the two term RAMs. A result word is held until the next
// nonzero term or the run end is found and shows the cycle after; the last
// word shows in the cycle in which busy drops. No stalls.
// Reset (rst_ni, asynchronous, active low) empties both stores at once.

module sparse_polynomial_add_unit
  import spa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              kind_i,
  input  logic [ExpW-1:0]         exponent_i,
  input  logic signed [CoefW-1:0] coefficient_i,
  output logic                    strobe_o,
  output logic [ExpW-1:0]         term_exponent_o,
  output logic signed [CoefW-1:0] term_coefficient_o,
  output logic                    last_term_o,
  output logic                    empty_sum_o,
  output logic                    overflow_seen_o
);

  // The two stores are plain RAMs with a registered read. Their contents are
  // never cleared: the merge core only reads entries below each fill count,
  // and the counts return to zero at the end of every merge run.
  spa_ram_req_t req_first, req_second;
  spa_term_t    rdata_first, rdata_second;

  spa_term_ram u_first_ram (
    .clk_i   (clk_i),
    .req_i   (req_first),
    .rdata_o (rdata_first)
  );

  spa_term_ram u_second_ram (
    .clk_i   (clk_i),
    .req_i   (req_second),
    .rdata_o (rdata_second)
  );

  // The core issues the read for the next pointer pair in the same cycle in
  // which it compares the current pair, so one term is decided per cycle.
  // The newest nonzero term is held back one step so that the final word of
  // a run can carry last_term; a run with no nonzero term sends a single
  // word flagged empty_sum.
  spa_merge_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .exponent_i         (exponent_i),
    .coefficient_i      (coefficient_i),
    .req_first_o        (req_first),
    .req_second_o       (req_second),
    .rdata_first_i      (rdata_first),
    .rdata_second_i     (rdata_second),
    .strobe_o           (strobe_o),
    .term_exponent_o    (term_exponent_o),
    .term_coefficient_o (term_coefficient_o),
    .last_term_o        (last_term_o),
    .empty_sum_o        (empty_sum_o),
    .overflow_seen_o    (overflow_seen_o)
  );

endmodule
